// ===== hw/rtl/sbdc_pkg.sv =====
// Shared types, constants and functions of the save blob deframer.
// No dependencies; every other file of the block imports this package.
package sbdc_pkg;

  localparam int MAX_PAYLOAD = 65535;
  localparam int HDR_LEN     = 14;
  localparam int MAGIC_LEN   = 6;
  localparam int PHASE_MOD   = 6;
  localparam int CNT_W       = 17;
  localparam int LEN_W       = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX    = CNT_W'(MAX_PAYLOAD + HDR_LEN + 1);
  localparam logic [CNT_W-1:0] MAX_PAY_CNT  = CNT_W'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] CAP_RESET    = CNT_W'(65536);
  localparam logic [LEN_W-1:0] LEN_SAT      = {LEN_W{1'b1}};
  localparam logic [31:0]      CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0]      CRC_TOP      = 32'h80000000;
  localparam logic [7:0]       DECODE_BIAS  = 8'd21;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_HEADER = 2'd1;
  localparam status_t ST_LONG   = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             done_res;
    status_t          status;
    logic             crc_ok;
    logic [LEN_W-1:0] payload_length;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h44; // D
      3'd1:    c = 8'h47; // G
      3'd2:    c = 8'h44; // D
      3'd3:    c = 8'h41; // A
      3'd4:    c = 8'h54; // T
      3'd5:    c = 8'h41; // A
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // {ok, digit}: plain hex digits only
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else                               r = 5'd0;
    return r;
  endfunction

  // One byte of the CRC variant: round 1 logical shift, rounds 2..8 arithmetic
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] x;
    logic [31:0] s;
    x = {24'h0, b ^ crc[7:0]};
    x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    for (int r = 0; r < 7; r++) begin
      s = (x >> 1) | (x & CRC_TOP);
      x = x[0] ? (s ^ CRC_POLY) : s;
    end
    return x ^ (crc >> 8);
  endfunction

endpackage

// ===== hw/rtl/sbdc_in_reg.sv =====
// Input register stage of the deframer: holds one raw item until the core takes it.
// Depends on sbdc_pkg.
module sbdc_in_reg
  import sbdc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  item_t load_item,
  input  logic  advance,
  output logic  held,
  output item_t item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
    end
  end

endmodule

// ===== hw/rtl/sbdc_core.sv =====
// Blob state and per-byte decode: header check, hex field, de-obfuscation, CRC, status.
// Depends on sbdc_pkg.
module sbdc_core
  import sbdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data,
  input  item_t            item,
  input  logic             commit,
  output logic             has_result,
  output result_t          result
);

  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] byte_count;
  logic             magic_match;
  logic             hex_valid;
  logic [31:0]      stored_check;
  logic [31:0]      running_crc;
  logic [2:0]       offset_phase;

  logic [CNT_W-1:0] byte_count_next;
  logic             magic_match_next;
  logic             hex_valid_next;
  logic [31:0]      stored_check_next;
  logic [31:0]      running_crc_next;
  logic [2:0]       offset_phase_next;

  logic             in_magic, in_hex;
  logic [4:0]       hex;
  logic [CNT_W-1:0] pay_idx;
  logic [2:0]       ph;
  logic [7:0]       dec;
  logic             emit;
  logic [CNT_W-1:0] len;
  status_t          st;

  always_comb begin
    in_magic = byte_count < CNT_W'(MAGIC_LEN);
    in_hex   = !in_magic && byte_count < CNT_W'(HDR_LEN);
    hex      = hex_digit(item.in_byte);
    pay_idx  = byte_count - CNT_W'(HDR_LEN);
    ph       = (offset_phase < 3'(PHASE_MOD)) ? offset_phase : 3'd0;
    dec      = item.in_byte - DECODE_BIAS - {5'd0, ph};

    byte_count_next   = (byte_count < COUNT_MAX) ? byte_count + 1'b1 : byte_count;
    magic_match_next  = magic_match;
    hex_valid_next    = hex_valid;
    stored_check_next = stored_check;
    running_crc_next  = running_crc;
    offset_phase_next = offset_phase;
    emit              = 1'b0;

    if (in_magic) begin
      if (item.in_byte != magic_byte(byte_count[2:0])) magic_match_next = 1'b0;
    end else if (in_hex) begin
      if (!hex[4]) hex_valid_next = 1'b0;
      else stored_check_next = {stored_check[27:0], hex[3:0]};
    end else begin
      offset_phase_next = (ph >= 3'(PHASE_MOD - 1)) ? 3'd0 : ph + 3'd1;
      running_crc_next  = crc_fold(running_crc, dec);
      emit = magic_match && ({1'b0, pay_idx} + 18'd2 <= {1'b0, capacity})
             && (pay_idx < MAX_PAY_CNT);
    end

    len = (byte_count_next > CNT_W'(HDR_LEN)) ? byte_count_next - CNT_W'(HDR_LEN) : '0;
    if (byte_count_next <= CNT_W'(HDR_LEN) || !magic_match_next) st = ST_HEADER;
    else if ({1'b0, len} + 18'd1 > {1'b0, capacity} || len > MAX_PAY_CNT) st = ST_LONG;
    else st = ST_OK;

    has_result = emit || item.is_last;

    result.out_byte       = emit ? dec : 8'd0;
    result.byte_valid     = emit;
    result.done_res       = item.is_last;
    result.status         = item.is_last ? st : ST_OK;
    result.crc_ok         = item.is_last && st == ST_OK && hex_valid_next
                            && running_crc_next == stored_check_next;
    result.payload_length = !item.is_last ? '0 :
                            (len > CNT_W'(LEN_SAT)) ? LEN_SAT : len[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  // the last byte of a blob returns all blob state to its reset value
  always_ff @(posedge clk) begin
    if (rst || (commit && item.is_last)) begin
      byte_count   <= '0;
      magic_match  <= 1'b1;
      hex_valid    <= 1'b1;
      stored_check <= '0;
      running_crc  <= '0;
      offset_phase <= '0;
    end else if (commit) begin
      byte_count   <= byte_count_next;
      magic_match  <= magic_match_next;
      hex_valid    <= hex_valid_next;
      stored_check <= stored_check_next;
      running_crc  <= running_crc_next;
      offset_phase <= offset_phase_next;
    end
  end

endmodule

// ===== hw/rtl/sbdc_out_reg.sv =====
// Result register of the deframer: holds one result item until the sink takes it.
// Depends on sbdc_pkg.
module sbdc_out_reg
  import sbdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_result,
  input  logic    stall,
  output logic    room,
  output logic    valid,
  output result_t result
);

  assign room = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      result <= load_result;
    end
  end

endmodule

// ===== hw/rtl/save_blob_deframer_crc.sv =====
// Top level of the save blob deframer: input register, decode core, result register.
// Depends on sbdc_pkg, sbdc_in_reg, sbdc_core, sbdc_out_reg.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_stall    in_byte, is_last
//   out       source     out_valid/out_stall  out_byte, byte_valid, done_res, status,
//                                             crc_ok, payload_length
//   cfg       sink       cfg_valid/cfg_ready  cfg_data (capacity)
//
// One byte per cycle sustained while the output does not stall; a byte passes the input
// register, then the single-pass decode and CRC, and its result waits in the result
// register until the sink takes it.
// Bytes that yield no result (header bytes, suppressed payload) retire without a slot.
// Reset is synchronous; capacity returns to 65536 and no blob is open.
// A stalled output holds its item; the input stalls only when a held byte needs the
// result register and that register is full and stalled.
module save_blob_deframer_crc
  import sbdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             is_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             done_res,
  output logic [1:0]       status,
  output logic             crc_ok,
  output logic [LEN_W-1:0] payload_length,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  item_t   in_item, held_item;
  logic    held, advance, has_result, room;
  result_t core_result, out_result;

  assign in_item  = '{in_byte: in_byte, is_last: is_last};
  assign advance  = held && (!has_result || room);
  assign in_stall = held && !advance;
  assign cfg_ready = 1'b1;

  sbdc_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .load      (in_valid && !in_stall),
    .load_item (in_item),
    .advance   (advance),
    .held      (held),
    .item      (held_item)
  );

  sbdc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .item       (held_item),
    .commit     (advance),
    .has_result (has_result),
    .result     (core_result)
  );

  sbdc_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (held && has_result),
    .load_result (core_result),
    .stall       (out_stall),
    .room        (room),
    .valid       (out_valid),
    .result      (out_result)
  );

  assign out_byte       = out_result.out_byte;
  assign byte_valid     = out_result.byte_valid;
  assign done_res       = out_result.done_res;
  assign status         = out_result.status;
  assign crc_ok         = out_result.crc_ok;
  assign payload_length = out_result.payload_length;

endmodule

// ===== hw/rtl/sbdc_checker.sv =====
// Port-level checks of the save blob deframer, bound to the top level.
// Depends on sbdc_pkg and save_blob_deframer_crc.
module sbdc_checker
  import sbdc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic [7:0]       in_byte,
  input logic             is_last,
  input logic             out_valid,
  input logic             out_stall,
  input logic [7:0]       out_byte,
  input logic             byte_valid,
  input logic             done_res,
  input logic [1:0]       status,
  input logic             crc_ok,
  input logic [LEN_W-1:0] payload_length,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CNT_W-1:0] cfg_data
);

  // hold a stalled result item: valid and every field but crc_ok stay stable
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(done_res) && $stable(status) && $stable(payload_length))
    else $error("stalled result item changed");

  a_has_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_valid || done_res)
    else $error("result item carries neither a byte nor a done");

  a_mid_blob_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == ST_OK && !crc_ok && payload_length == '0)
    else $error("status fields set on a mid-blob item");

  a_crc_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && status != ST_OK |-> !crc_ok && status <= ST_LONG)
    else $error("crc_ok with failing status or bad status code");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'd0)
    else $error("suppressed byte is not zero");

endmodule

bind save_blob_deframer_crc sbdc_checker u_sbdc_checker (.*);

// ===== test/tb_save_blob_deframer_crc.sv =====
// Testbench for save_blob_deframer_crc: framed blobs are sent byte by byte, and every
// result is checked against a deframer predictor kept in this module.
// Depends on sbdc_pkg and the save_blob_deframer_crc RTL.
module tb_save_blob_deframer_crc;
  timeunit 1ns;
  timeprecision 1ps;
  import sbdc_pkg::*;

  localparam int BLOB_HDR = 14;
  localparam int MAGIC_N = 6;
  localparam int PAY_LIMIT = 65535;
  localparam int COUNT_TOP = PAY_LIMIT + BLOB_HDR + 1;
  localparam int BIAS = 21;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 640;
  localparam logic [31:0] POLY_REFL = 32'hEDB88320;
  localparam logic [8*MAGIC_N-1:0] MAGIC_STR = "DGDATA";
  // space, signs, x, NUL and the neighbors of each digit range
  localparam logic [8*11-1:0] NON_HEX = {" +-x", 8'h00, "/:@G`g"};

  typedef enum int {BLOB_GOOD, BLOB_WRONG_CRC, BLOB_BAD_HEX, BLOB_BAD_MAGIC, BLOB_NOISE}
    blob_kind_e;
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_mode_e;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_byte;
  logic             is_last;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_byte;
  logic             byte_valid;
  logic             done_res;
  logic [1:0]       status;
  logic             crc_ok;
  logic [LEN_W-1:0] payload_length;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  save_blob_deframer_crc dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [CNT_W-1:0] cap_reg;
  int               blob_count;
  bit               magic_good;
  bit               digits_good;
  logic [31:0]      check_word;
  logic [31:0]      crc_acc;
  int               rot_phase;
  result_t          deframe_q[$];

  int       errors;
  int       items_sent;
  int       burst_left;
  int       quiet_cycles;
  rx_mode_e rx_mode;
  int       rx_left;
  int       run_left;
  bit       run_level;

  function automatic logic [7:0] magic_at(input int k);
    return MAGIC_STR[8*(MAGIC_N-1-k) +: 8];
  endfunction

  // first round shifts in a zero, the other seven replicate the top bit
  function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] x;
    logic [31:0] sh;
    x = {24'd0, b ^ acc[7:0]};
    for (int r = 0; r < 8; r++) begin
      sh = (r == 0) ? {1'b0, x[31:1]} : {x[31], x[31:1]};
      x = x[0] ? (sh ^ POLY_REFL) : sh;
    end
    return x ^ (acc >> 8);
  endfunction

  // {is_digit, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
    return 5'd0;
  endfunction

  function automatic void clear_blob_state();
    blob_count = 0;
    magic_good = 1'b1;
    digits_good = 1'b1;
    check_word = '0;
    crc_acc = '0;
    rot_phase = 0;
  endfunction

  // Advance the deframer by one byte; return 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, input bit is_end,
                                      output result_t r);
    int          pos;
    int          idx;
    int          ph;
    int          len;
    logic [7:0]  ob;
    logic [4:0]  hv;
    bit          emit;
    pos = blob_count;
    ob = '0;
    emit = 1'b0;
    if (blob_count < COUNT_TOP) blob_count++;
    if (pos < MAGIC_N) begin
      if (b != magic_at(pos)) magic_good = 1'b0;
    end else if (pos < BLOB_HDR) begin
      hv = hex_val(b);
      if (!hv[4]) digits_good = 1'b0;
      else check_word = {check_word[27:0], hv[3:0]};
    end else begin
      idx = pos - BLOB_HDR;
      ph = (rot_phase < 6) ? rot_phase : 0;
      ob = 8'(int'(b) - BIAS - ph);
      rot_phase = (ph >= 5) ? 0 : ph + 1;
      crc_acc = crc_step(crc_acc, ob);
      emit = magic_good && (idx + 2 <= int'(cap_reg)) && (idx < PAY_LIMIT);
    end
    r = '0;
    if (emit) begin
      r.out_byte = ob;
      r.byte_valid = 1'b1;
    end
    if (is_end) begin
      len = (blob_count > BLOB_HDR) ? blob_count - BLOB_HDR : 0;
      r.done_res = 1'b1;
      if (blob_count <= BLOB_HDR || !magic_good) begin
        r.status = ST_HEADER;
      end else if (len + 1 > int'(cap_reg) || len > PAY_LIMIT) begin
        r.status = ST_LONG;
      end else begin
        r.status = ST_OK;
        r.crc_ok = digits_good && (crc_acc == check_word);
      end
      r.payload_length = LEN_W'((len > PAY_LIMIT) ? PAY_LIMIT : len);
      clear_blob_state();
    end
    return emit || is_end;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", name, want, got);
      errors++;
    end
  endfunction

  // check the oldest expectation first, then predict the byte taken at this edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t nxt;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {out_byte, byte_valid, done_res, status, crc_ok, payload_length};
        if (deframe_q.size() == 0) begin
          $error("result with nothing expected: out_byte %0h done_res %0b", out_byte,
                 done_res);
          errors++;
        end else begin
          want = deframe_q.pop_front();
          compare_field("out_byte", want.out_byte, got.out_byte);
          compare_field("byte_valid", want.byte_valid, got.byte_valid);
          compare_field("done_res", want.done_res, got.done_res);
          compare_field("status", want.status, got.status);
          compare_field("crc_ok", want.crc_ok, got.crc_ok);
          compare_field("payload_length", want.payload_length, got.payload_length);
        end
      end
      if (in_valid && !in_stall) begin
        if (deframe_byte(in_byte, is_last, nxt)) deframe_q.push_back(nxt);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stall pattern: free, light, heavy, or runs of random length
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_level = !run_level;
          run_left = $urandom_range(1, 12);
        end
        run_left--;
        out_stall <= run_level;
      end
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so that back-to-back items need no drop.
  task automatic send_byte(input logic [7:0] b, input bit is_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_byte = b;
    is_last = is_end;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Header bytes retire without a result, so the wait goes on past the last expected one.
  task automatic drain();
    in_valid = 1'b0;
    while (deframe_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    drain();
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Build one framed blob around plen random payload bytes; a cut > 0 shorter than the blob ends it early.
  task automatic send_blob(input int plen, input blob_kind_e kind, input int cut = 0);
    logic [7:0]  dec[];
    logic [7:0]  raw[];
    logic [31:0] crc;
    logic [4:0]  hv;
    int          n;
    int          k;
    int          d;
    dec = new[plen];
    raw = new[BLOB_HDR + plen];
    crc = '0;
    for (k = 0; k < plen; k++) begin
      if ($urandom_range(0, 7) == 0) dec[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else dec[k] = 8'($urandom);
      crc = crc_step(crc, dec[k]);
    end
    if (kind == BLOB_WRONG_CRC) crc ^= 32'd1 << $urandom_range(0, 31);
    for (k = 0; k < MAGIC_N; k++) raw[k] = magic_at(k);
    for (k = 0; k < 8; k++) begin
      d = crc[4*(7-k) +: 4];
      if (d < 10) raw[MAGIC_N+k] = 8'("0" + d);
      else raw[MAGIC_N+k] = 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
    end
    for (k = 0; k < plen; k++) raw[BLOB_HDR+k] = 8'(dec[k] + BIAS + k % 6);
    case (kind)
      BLOB_BAD_MAGIC: begin
        k = $urandom_range(0, MAGIC_N - 1);
        raw[k] ^= 8'($urandom_range(1, 255));
      end
      BLOB_BAD_HEX: begin
        k = $urandom_range(MAGIC_N, BLOB_HDR - 1);
        if ($urandom_range(0, 1)) begin
          raw[k] = NON_HEX[8*$urandom_range(0, 10) +: 8];
        end else begin
          do begin
            raw[k] = 8'($urandom);
            hv = hex_val(raw[k]);
          end while (hv[4]);
        end
      end
      BLOB_NOISE: foreach (raw[j]) raw[j] = 8'($urandom);
      default: ;
    endcase
    n = (cut > 0 && cut < raw.size()) ? cut : raw.size();
    for (k = 0; k < n; k++) send_byte(raw[k], k == n - 1);
  endtask

  task automatic test_short_blobs();
    send_byte(8'hFF, 1'b1);
    send_blob(0, BLOB_GOOD);
    send_blob(5, BLOB_GOOD, 9);
    send_blob(1, BLOB_GOOD);
  endtask

  task automatic test_header_errors();
    send_blob(6, BLOB_BAD_MAGIC);
    send_blob(6, BLOB_BAD_HEX);
    send_blob(7, BLOB_WRONG_CRC);
    send_blob(4, BLOB_NOISE);
    send_blob(12, BLOB_GOOD);
  endtask

  task automatic test_capacity_limits();
    write_capacity(CNT_W'(1));
    send_blob(1, BLOB_GOOD);
    write_capacity(CNT_W'(3));
    send_blob(2, BLOB_GOOD);
    send_blob(4, BLOB_GOOD);
    write_capacity(CNT_W'(PAY_LIMIT));
    send_blob(3, BLOB_GOOD);
    write_capacity(CAP_RESET);
  endtask

  task automatic test_random_blobs();
    int         start;
    int         w;
    int         plen;
    int         cut;
    blob_kind_e kind;
    start = items_sent;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_capacity(CAP_RESET);
        1: write_capacity(CNT_W'($urandom_range(1, 24)));
        2: write_capacity(CNT_W'($urandom_range(1, 65536)));
        3: write_capacity(CNT_W'(1));
        4: write_capacity(CNT_W'($urandom_range(8, 48)));
        default: write_capacity(CNT_W'(PAY_LIMIT));
      endcase
      while (items_sent - start < (ph + 1) * RANDOM_ITEMS / 6) begin
        w = $urandom_range(0, 99);
        cut = 0;
        if (w < 68) kind = BLOB_GOOD;
        else if (w < 76) kind = BLOB_WRONG_CRC;
        else if (w < 84) kind = BLOB_BAD_HEX;
        else if (w < 91) kind = BLOB_BAD_MAGIC;
        else if (w < 95) kind = BLOB_NOISE;
        else begin
          kind = BLOB_GOOD;
          cut = $urandom_range(1, BLOB_HDR);
        end
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 30);
        send_blob(plen, kind, cut);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = '0;
    is_last = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cap_reg = CAP_RESET;
    clear_blob_state();
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    quiet_cycles = 0;
    rx_left = 0;
    run_left = 0;
    run_level = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_short_blobs();
    test_header_errors();
    test_capacity_limits();
    test_random_blobs();
    drain();
    repeat (4) @(negedge clk);
    if (errors == 0 && deframe_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== save_blob_deframer_crc.f =====
hw/rtl/sbdc_pkg.sv
hw/rtl/sbdc_in_reg.sv
hw/rtl/sbdc_core.sv
hw/rtl/sbdc_out_reg.sv
hw/rtl/save_blob_deframer_crc.sv
hw/rtl/sbdc_checker.sv
test/tb_save_blob_deframer_crc.sv
